// ----- hdl/kmap4_greedy_grouping_assert.svh -----
// Assertion macros for the grouping block checkers.
`ifndef KMAP4_GREEDY_GROUPING_ASSERT_SVH
`define KMAP4_GREEDY_GROUPING_ASSERT_SVH

// Same-cycle implication, off during reset.
`define KMG_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset.
`define KMG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/kmg_pkg.sv -----
package kmg_pkg;

   localparam int NUM_SIZES = 9;

   // map cell {row,col} -> minterm (Gray order on both axes)
   localparam logic [3:0] CELL_MINTERM [16] = '{
      4'd0, 4'd1, 4'd3, 4'd2, 4'd4, 4'd5, 4'd7, 4'd6,
      4'd12, 4'd13, 4'd15, 4'd14, 4'd8, 4'd9, 4'd11, 4'd10};

   localparam logic [2:0] SIZE_ROWS [NUM_SIZES] = '{
      3'd4, 3'd2, 3'd4, 3'd1, 3'd4, 3'd2, 3'd1, 3'd2, 3'd1};
   localparam logic [2:0] SIZE_COLS [NUM_SIZES] = '{
      3'd4, 3'd4, 3'd2, 3'd4, 3'd1, 3'd2, 3'd2, 3'd1, 3'd1};

   localparam logic [3:0] LAST_SIZE = 4'(NUM_SIZES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FLUSH
   } kmg_state_type;

   typedef struct packed {
      logic        found;
      logic [1:0]  top;
      logic [1:0]  left;
      logic [15:0] cells;
   } kmg_hit_type;

   typedef struct packed {
      logic [15:0] cells;
      logic [1:0]  top;
      logic [1:0]  left;
      logic [2:0]  rows;
      logic [2:0]  cols;
      logic        valid;
      logic        last;
   } kmg_word_type;

   // minterm mask of an h x w rectangle at (r0,c0), wrapping on both axes
   function automatic logic [15:0] rect_mask(input logic [2:0] h, input logic [2:0] w,
                                             input logic [1:0] r0, input logic [1:0] c0);
      logic [15:0] m;
      logic [1:0]  rr;
      logic [1:0]  cc;
      m = '0;
      for (int dr = 0; dr < 4; dr++) begin
         for (int dc = 0; dc < 4; dc++) begin
            rr = r0 + 2'(dr);
            cc = c0 + 2'(dc);
            if (3'(dr) < h && 3'(dc) < w) begin
               m[CELL_MINTERM[{rr, cc}]] = 1'b1;
            end
         end
      end
      return m;
   endfunction

endpackage

// ----- hdl/kmg_finder.sv -----
// Finds the first group of the current size: first uncovered cell in
// row-major order whose corner rectangles (TL, BL, BR, TR) fit in the ones.
module kmg_finder import kmg_pkg::*; (
   input  logic [15:0] ones,
   input  logic [15:0] covered,
   input  logic [3:0]  size_idx,
   output kmg_hit_type hit
);

   logic [2:0] h;
   logic [2:0] w;

   assign h = SIZE_ROWS[size_idx];
   assign w = SIZE_COLS[size_idx];

   always_comb begin
      logic [3:0]  ci;
      logic [1:0]  r;
      logic [1:0]  c;
      logic [2:0]  up_t;
      logic [2:0]  lf_t;
      logic [1:0]  cand_r [4];
      logic [1:0]  cand_c [4];
      logic [15:0] m;
      hit = '0;
      // walk backwards so the earliest cell and corner wins
      for (int i = 15; i >= 0; i--) begin
         ci = 4'(i);
         r = ci[3:2];
         c = ci[1:0];
         up_t = 3'(r) + 3'd5 - h;
         lf_t = 3'(c) + 3'd5 - w;
         cand_r[0] = r;          cand_c[0] = c;
         cand_r[1] = up_t[1:0];  cand_c[1] = c;
         cand_r[2] = up_t[1:0];  cand_c[2] = lf_t[1:0];
         cand_r[3] = r;          cand_c[3] = lf_t[1:0];
         for (int k = 3; k >= 0; k--) begin
            m = rect_mask(h, w, cand_r[k], cand_c[k]);
            if (!covered[CELL_MINTERM[ci]] && (m & ~ones) == 16'd0) begin
               hit.found = 1'b1;
               hit.top   = cand_r[k];
               hit.left  = cand_c[k];
               hit.cells = m;
            end
         end
      end
   end

endmodule

// ----- hdl/kmg_outreg.sv -----
// Output word register; takes a new word whenever it is empty or draining.
module kmg_outreg import kmg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  kmg_word_type push_word,
   output logic         free,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [15:0]  rsp_group_cells,
   output logic [1:0]   rsp_top_row,
   output logic [1:0]   rsp_left_col,
   output logic [2:0]   rsp_group_rows,
   output logic [2:0]   rsp_group_cols,
   output logic         rsp_group_valid,
   output logic         rsp_last_group
);

   logic         valid_ff;
   logic         valid_in;
   kmg_word_type word_ff;

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (push) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         word_ff <= push_word;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_group_cells = word_ff.cells;
   assign rsp_top_row     = word_ff.top;
   assign rsp_left_col    = word_ff.left;
   assign rsp_group_rows  = word_ff.rows;
   assign rsp_group_cols  = word_ff.cols;
   assign rsp_group_valid = word_ff.valid;
   assign rsp_last_group  = word_ff.last;

endmodule

// ----- hdl/kmap4_greedy_grouping.sv -----
// channel | direction | ports
// req     | in        | req_valid, req_ready, req_minterm_mask
// rsp     | out       | rsp_valid, rsp_ready, rsp_group_* , rsp_top_row, rsp_left_col,
//         |           | rsp_last_group
//
// One word is accepted, then searched size by size over the nine sizes, largest first,
// one group at a time, then flushed; the group finder is evaluated once per cycle.
// Each group is held back until the next group is found or the search ends, so its last flag is known.
// Synchronous active-high reset clears the sequencer and the output valid.
// A stalled rsp side holds the sequencer only when a word must be handed on.
module kmap4_greedy_grouping import kmg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_minterm_mask,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_group_cells,
   output logic [1:0]  rsp_top_row,
   output logic [1:0]  rsp_left_col,
   output logic [2:0]  rsp_group_rows,
   output logic [2:0]  rsp_group_cols,
   output logic        rsp_group_valid,
   output logic        rsp_last_group
);

   kmg_state_type state_ff, state_in;
   logic [15:0]   ones_ff, ones_in;
   logic [15:0]   covered_ff, covered_in;
   logic [3:0]    size_ff, size_in;
   logic          pend_vld_ff, pend_vld_in;
   kmg_word_type  pend_ff, pend_in;

   kmg_hit_type   hit;
   logic          out_free;
   logic          push;
   kmg_word_type  push_word;

   kmg_finder u_finder (
      .ones     (ones_ff),
      .covered  (covered_ff),
      .size_idx (size_ff),
      .hit      (hit)
   );

   kmg_outreg u_outreg (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .push_word       (push_word),
      .free            (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_group_cells (rsp_group_cells),
      .rsp_top_row     (rsp_top_row),
      .rsp_left_col    (rsp_left_col),
      .rsp_group_rows  (rsp_group_rows),
      .rsp_group_cols  (rsp_group_cols),
      .rsp_group_valid (rsp_group_valid),
      .rsp_last_group  (rsp_last_group)
   );

   always_comb begin
      state_in    = state_ff;
      ones_in     = ones_ff;
      covered_in  = covered_ff;
      size_in     = size_ff;
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      req_ready   = 1'b0;
      push        = 1'b0;
      push_word   = pend_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ones_in     = req_minterm_mask;
               covered_in  = '0;
               size_in     = '0;
               pend_vld_in = 1'b0;
               state_in    = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (hit.found) begin
               if (!pend_vld_ff || out_free) begin
                  push           = pend_vld_ff;
                  push_word.last = 1'b0;
                  pend_in.cells  = hit.cells;
                  pend_in.top    = hit.top;
                  pend_in.left   = hit.left;
                  pend_in.rows   = SIZE_ROWS[size_ff];
                  pend_in.cols   = SIZE_COLS[size_ff];
                  pend_in.valid  = 1'b1;
                  pend_in.last   = 1'b0;
                  pend_vld_in    = 1'b1;
                  covered_in     = covered_ff | hit.cells;
               end
            end else if (size_ff == LAST_SIZE) begin
               state_in = ST_FLUSH;
            end else begin
               size_in = size_ff + 4'd1;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               push = 1'b1;
               if (pend_vld_ff) begin
                  push_word.last = 1'b1;
               end else begin
                  // no ones at all: single empty word
                  push_word      = '0;
                  push_word.last = 1'b1;
               end
               pend_vld_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pend_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      ones_ff    <= ones_in;
      covered_ff <= covered_in;
      size_ff    <= size_in;
      pend_ff    <= pend_in;
   end

endmodule

// ----- hdl/kmg_checker.sv -----
`include "kmap4_greedy_grouping_assert.svh"

module kmg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [15:0] req_minterm_mask,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_group_cells,
   input logic [1:0]  rsp_top_row,
   input logic [1:0]  rsp_left_col,
   input logic [2:0]  rsp_group_rows,
   input logic [2:0]  rsp_group_cols,
   input logic        rsp_group_valid,
   input logic        rsp_last_group
);

   `KMG_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req_minterm_mask), "req word dropped or changed while waiting")

   `KMG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_group_cells) && $stable(rsp_top_row) && $stable(rsp_left_col) && $stable(rsp_last_group), "rsp word changed while stalled")

   `KMG_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "accepted a word while still searching")

   `KMG_ASSERT_NOW(a_empty_word, rsp_valid && !rsp_group_valid, rsp_last_group && rsp_group_cells == 16'd0 && rsp_group_rows == 3'd0, "empty result not final or not cleared")

   `KMG_ASSERT_NOW(a_group_area, rsp_valid && rsp_group_valid, $countones(rsp_group_cells) == 32'(rsp_group_rows) * 32'(rsp_group_cols), "group cell count does not match its size")

endmodule

bind kmap4_greedy_grouping kmg_checker u_kmg_checker (.*);
